// ===== hdl/tmmf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmmf_pkg
// Types and fixed constants shared by the trimmed moving mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tmmf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int QUOT_W   = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [QUOT_W-1:0]          quot_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct packed {
    logic clear;
    logic en;
  } acc_ctrl_t;

  typedef struct packed {
    logic done;
    logic neg;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/tmmf_sample_if.sv =====
// ----------------------------------------------------------------------------
// tmmf_sample_if
// Valid/ready channel that carries one raw sensor sample per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmmf_sample_if;
  import tmmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/tmmf_filtered_if.sv =====
// ----------------------------------------------------------------------------
// tmmf_filtered_if
// Valid/ready channel that carries one filtered sample per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmmf_filtered_if;
  import tmmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

// ===== hdl/tmmf_cell.sv =====
// ----------------------------------------------------------------------------
// tmmf_cell
// One window entry. On a shift it takes the value of its upstream neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module tmmf_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  tmmf_pkg::sample_t d,
  output tmmf_pkg::sample_t q
);
  import tmmf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end
endmodule

`default_nettype wire

// ===== hdl/tmmf_acc.sv =====
// ----------------------------------------------------------------------------
// tmmf_acc
// Running maximum, minimum and sum over the entries leaving the chain tail,
// with a registered trimmed sum (sum less one maximum and one minimum).
// ----------------------------------------------------------------------------
`default_nettype none

module tmmf_acc #(
  parameter int SUM_W = 21
) (
  input  logic                     clk,
  input  tmmf_pkg::acc_ctrl_t      ctrl,
  input  tmmf_pkg::sample_t        value,
  output logic signed [SUM_W-1:0]  trimmed
);
  import tmmf_pkg::*;

  localparam int EXT_W = SUM_W - SAMPLE_W;

  sample_t                  hi;
  sample_t                  lo;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  value_ext;
  logic signed [SUM_W-1:0]  hi_ext;
  logic signed [SUM_W-1:0]  lo_ext;

  assign value_ext = {{EXT_W{value[SAMPLE_W-1]}}, value};
  assign hi_ext    = {{EXT_W{hi[SAMPLE_W-1]}}, hi};
  assign lo_ext    = {{EXT_W{lo[SAMPLE_W-1]}}, lo};

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      hi  <= SAMPLE_MIN;
      lo  <= SAMPLE_MAX;
      sum <= '0;
    end else if (ctrl.en) begin
      if (value > hi) begin
        hi <= value;
      end
      if (value < lo) begin
        lo <= value;
      end
      sum <= sum + value_ext;
    end
    // The true trimmed sum always fits, so wrapping intermediates are harmless.
    trimmed <= sum - hi_ext - lo_ext;
  end
endmodule

`default_nettype wire

// ===== hdl/tmmf_div.sv =====
// ----------------------------------------------------------------------------
// tmmf_div
// Divider by a fixed divisor, done as a multiplication by the rounded-up
// reciprocal, with the dividend magnitude and then the product registered.
// Returns the magnitude of the quotient and the sign of the dividend, so the
// caller gets truncation toward zero by negating when the sign is set.
// ----------------------------------------------------------------------------
`default_nettype none

module tmmf_div #(
  parameter int SUM_W   = 21,
  parameter int DIVISOR = 18
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [SUM_W-1:0]  num,
  output tmmf_pkg::div_stat_t      stat,
  output tmmf_pkg::quot_t          quot
);
  import tmmf_pkg::*;

  // With SHIFT = SUM_W + clog2(DIVISOR) the rounded-up reciprocal gives the
  // exact floor quotient for every magnitude below 2**SUM_W.
  localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic                    mag_valid;
  logic                    done_r;
  logic                    neg_r;
  logic [SUM_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic signed [SUM_W-1:0] num_neg;

  assign num_neg = -num;
  assign stat    = '{done: done_r, neg: neg_r};
  assign quot    = prod[SHIFT +: QUOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      mag_valid <= start;
      done_r    <= mag_valid;
    end
    if (start) begin
      neg_r <= num[SUM_W-1];
      mag   <= num[SUM_W-1] ? $unsigned(num_neg) : $unsigned(num);
    end
    if (mag_valid) begin
      prod <= PROD_W'(mag) * PROD_W'(RECIP);
    end
  end
endmodule

`default_nettype wire

// ===== hdl/trimmed_moving_mean_filter_top.sv =====
// ----------------------------------------------------------------------------
// trimmed_moving_mean_filter_top
// Moving-window mean of the last WINDOW samples with one maximum and one
// minimum removed, truncated toward zero.
//
// Channel raw takes one signed 16-bit sample per word; channel smooth gives
// one filtered word for every sample taken. The window is a row of WINDOW
// cells. A new sample shifts in at the head and the oldest drops off the
// tail; the row then rotates once around while a single compare/add unit
// collects maximum, minimum and sum from the tail. A divider then divides
// the trimmed sum by WINDOW-2 as a multiplication by a fixed reciprocal.
// A result is written to the output register after the rotation, the trim,
// the divider load and the divider's magnitude and product registers; a new
// sample is taken only once the previous result is in the output register.
// Reset clears all cells to zero, as if the window held zeros.
// The result waits in an output register; while smooth is stalled the block
// still accepts and processes the next sample, and holds before writing its
// result until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_moving_mean_filter_top #(
  parameter int WINDOW = 20
) (
  input  logic             clk,
  input  logic             rst,
  tmmf_sample_if.sink      raw,
  tmmf_filtered_if.source  smooth
);
  import tmmf_pkg::*;

  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW);
  localparam int DIVISOR = WINDOW - 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TRIM,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        scan_cnt;
  logic                    out_valid;
  sample_t                 filtered_r;

  logic                    accept;
  logic                    out_load;
  logic                    shift_en;
  sample_t                 head_d;
  sample_t                 chain_q [WINDOW];
  acc_ctrl_t               acc_ctrl;
  logic signed [SUM_W-1:0] trimmed;
  div_stat_t               div_stat;
  quot_t                   quot;

  assign raw.ready       = (state == S_IDLE);
  assign accept          = raw.valid && raw.ready;
  assign smooth.valid    = out_valid;
  assign smooth.filtered = filtered_r;
  assign out_load        = (state == S_DONE) && (!out_valid || smooth.ready);

  // Loading a sample and rotating the row are the same shift with a
  // different value entering the head cell.
  assign shift_en = accept || (state == S_SCAN);
  assign head_d   = (state == S_IDLE) ? raw.sample : chain_q[WINDOW-1];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      tmmf_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift_en),
        .d     (head_d),
        .q     (chain_q[i])
      );
    end else begin : g_body
      tmmf_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift_en),
        .d     (chain_q[i-1]),
        .q     (chain_q[i])
      );
    end
  end

  assign acc_ctrl = '{clear: accept, en: (state == S_SCAN)};

  tmmf_acc #(
    .SUM_W (SUM_W)
  ) u_acc (
    .clk     (clk),
    .ctrl    (acc_ctrl),
    .value   (chain_q[WINDOW-1]),
    .trimmed (trimmed)
  );

  tmmf_div #(
    .SUM_W   (SUM_W),
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_LOAD),
    .num   (trimmed),
    .stat  (div_stat),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid  <= 1'b1;
        filtered_r <= div_stat.neg ? sample_t'(-quot) : sample_t'(quot);
      end else if (out_valid && smooth.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == CNT_W'(WINDOW - 1)) begin
            state <= S_TRIM;
          end
        end
        // The last tail entry lands in the accumulator, and the trimmed sum is
        // registered in the cycle after.
        S_TRIM: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN) && (scan_cnt == '0))
    else $error("accepted word did not start a window rotation");

  a_scan_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_cnt <= CNT_W'(WINDOW - 1)))
    else $error("rotation counter ran past the window");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("output word appeared without a finished division");

endmodule

`default_nettype wire
